### rtl/shap_pkg.sv
// shap_pkg: shared types, codes and reset values of the sample history block
// no dependencies; front, back and top refer to it by scoped names
`default_nettype none

package shap_pkg;

    // field widths
    localparam int ACTION_W  = 2;
    localparam int SAMPLE_W  = 16;
    localparam int AGE_W     = 8;
    localparam int ROW_W     = 8;
    localparam int COUNT_W   = 8;
    localparam int NUM_W     = SAMPLE_W + ROW_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEPTH_DEF = 144;

    // reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = 16'd800;
    localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = 16'd1200;
    localparam logic [ROW_W-1:0]    PLOT_MAX_RST   = 8'd167;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOT_MAX   = 2'd2;

    // action codes on the input
    localparam logic [ACTION_W-1:0] ACT_STORE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

    // task codes between front and back
    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_REPORT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // plot row class of a stored sample
    localparam logic [1:0] ROW_ZERO = 2'd0;
    localparam logic [1:0] ROW_MAX  = 2'd1;
    localparam logic [1:0] ROW_DIV  = 2'd2;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SAMPLE_W-1:0] sample_value;
        logic [AGE_W-1:0]    age_index;
    } t_in;

    typedef struct packed {
        logic [ROW_W-1:0]    plot_row;
        logic [SAMPLE_W-1:0] entry_value;
        logic [SAMPLE_W-1:0] window_average;
        logic [COUNT_W-1:0]  held_count;
        logic                empty_flag;
    } t_out;

    typedef struct packed {
        logic [1:0]          op;
        logic [1:0]          cls;
        logic [SAMPLE_W-1:0] sample;
        logic [AGE_W-1:0]    age;
        logic [NUM_W-1:0]    num;
        logic [SAMPLE_W-1:0] den;
        logic [ROW_W-1:0]    pmax;
    } t_task;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [SAMPLE_W-1:0] reading;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_bk_stat;

endpackage

`default_nettype wire

### rtl/shap_ram.sv
// shap_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`default_nettype none

module shap_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 144
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/shap_div.sv
// shap_div: restoring divider, one quotient bit per cycle, done pulse at the end
// no dependencies
`default_nettype none

module shap_div #(
    parameter int DVW = 24,
    parameter int DSW = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [DVW-1:0] i_dividend,
    input  wire logic [DSW-1:0] i_divisor,
    output logic                o_done,
    output logic [DVW-1:0]      o_quot
);

    localparam int CNTW = $clog2(DVW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DSW:0]    r_rem;
    logic [DVW-1:0]  r_quo;
    logic [DSW-1:0]  r_div;

    logic [DSW:0] w_try;
    logic [DSW:0] w_diff;
    logic         w_ge;

    assign w_try  = {r_rem[DSW-1:0], r_quo[DVW-1]};
    assign w_ge   = w_try >= {1'b0, r_div};
    assign w_diff = w_try - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNTW'(DVW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_try;
            r_quo <= {r_quo[DVW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

### rtl/shap_front.sv
// shap_front: configuration registers, item classification and the task queue
// depends on shap_pkg
`default_nettype none

module shap_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [shap_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [shap_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire shap_pkg::t_in                    i_in_data,
    output logic                                  o_task_valid,
    input  wire logic                             i_task_ready,
    output shap_pkg::t_task                       o_task
);

    localparam int QCW = $clog2(shap_pkg::Q_DEPTH + 1);
    localparam int QIW = $clog2(shap_pkg::Q_DEPTH);

    logic [shap_pkg::SAMPLE_W-1:0] r_range_low;
    logic [shap_pkg::SAMPLE_W-1:0] r_range_high;
    logic [shap_pkg::ROW_W-1:0]    r_plot_max;

    shap_pkg::t_task r_q [shap_pkg::Q_DEPTH];
    logic [QIW-1:0]  r_wr, n_wr;
    logic [QIW-1:0]  r_rd, n_rd;
    logic [QCW-1:0]  r_qcnt, n_qcnt;

    shap_pkg::t_task               w_task;
    logic [shap_pkg::SAMPLE_W-1:0] w_offset;
    logic                          w_push;
    logic                          w_pop;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= shap_pkg::RANGE_LOW_RST;
            r_range_high <= shap_pkg::RANGE_HIGH_RST;
            r_plot_max   <= shap_pkg::PLOT_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                shap_pkg::CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                shap_pkg::CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                shap_pkg::CFG_PLOT_MAX:   r_plot_max   <= i_cfg_data[shap_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // classification: task code, row class and the scaled numerator
    assign w_offset = i_in_data.sample_value - r_range_low;

    always_comb begin
        w_task.sample = i_in_data.sample_value;
        w_task.age    = i_in_data.age_index;
        w_task.num    = shap_pkg::NUM_W'(w_offset) * shap_pkg::NUM_W'(r_plot_max);
        w_task.den    = r_range_high - r_range_low;
        w_task.pmax   = r_plot_max;
        unique case (i_in_data.action)
            shap_pkg::ACT_STORE: w_task.op = shap_pkg::OP_STORE;
            shap_pkg::ACT_READ:  w_task.op = shap_pkg::OP_READ;
            default:             w_task.op = shap_pkg::OP_REPORT;
        endcase
        if (i_in_data.sample_value <= r_range_low) begin
            w_task.cls = shap_pkg::ROW_ZERO;
        end else if (i_in_data.sample_value >= r_range_high) begin
            w_task.cls = shap_pkg::ROW_MAX;
        end else begin
            w_task.cls = shap_pkg::ROW_DIV;
        end
    end

    // task queue
    assign o_in_ready   = r_qcnt != QCW'(shap_pkg::Q_DEPTH);
    assign o_task_valid = r_qcnt != '0;
    assign o_task       = r_q[r_rd];
    assign w_push       = i_in_valid & o_in_ready;
    assign w_pop        = o_task_valid & i_task_ready;

    always_comb begin
        n_wr   = r_wr;
        n_rd   = r_rd;
        n_qcnt = r_qcnt;
        if (w_push) begin
            n_wr = (r_wr == QIW'(shap_pkg::Q_DEPTH - 1)) ? '0 : r_wr + QIW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == QIW'(shap_pkg::Q_DEPTH - 1)) ? '0 : r_rd + QIW'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_qcnt = r_qcnt + QCW'(1);
            2'b01:   n_qcnt = r_qcnt - QCW'(1);
            default: n_qcnt = r_qcnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_qcnt <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_task;
        end
    end

endmodule

`default_nettype wire

### rtl/shap_back.sv
// shap_back: ring store, running sum, cached average and the result register
// depends on shap_pkg, shap_ram and shap_div
`default_nettype none

module shap_back #(
    parameter int DEPTH = shap_pkg::DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_task_valid,
    output logic                  o_task_ready,
    input  wire shap_pkg::t_task  i_task,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output shap_pkg::t_out        o_out_data,
    output shap_pkg::t_bk_stat    o_stat
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SUMW = shap_pkg::SAMPLE_W + CW;
    localparam int DVW  = (SUMW > shap_pkg::NUM_W) ? SUMW : shap_pkg::NUM_W;
    localparam int DSW  = (CW > shap_pkg::SAMPLE_W) ? CW : shap_pkg::SAMPLE_W;
    localparam int XW   = ((PW > shap_pkg::AGE_W) ? PW : shap_pkg::AGE_W) + 2;
    localparam int EW   = $bits(shap_pkg::t_entry);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVICT = 3'd1;
    localparam logic [2:0] ST_ROW   = 3'd2;
    localparam logic [2:0] ST_WR    = 3'd3;
    localparam logic [2:0] ST_AVG   = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic [PW-1:0]                 r_wp, n_wp;
    logic [CW-1:0]                 r_count, n_count;
    logic [SUMW-1:0]               r_sum, n_sum;
    logic [shap_pkg::SAMPLE_W-1:0] r_avg, n_avg;
    logic [shap_pkg::ROW_W-1:0]    r_row, n_row;
    shap_pkg::t_task               r_task, n_task;
    logic                          r_ovalid, n_ovalid;
    shap_pkg::t_out                r_out, n_out;

    logic                 w_full;
    logic                 w_take;
    logic                 w_hit;
    logic [XW-1:0]        w_back;
    logic [PW-1:0]        w_slot;
    logic [PW-1:0]        w_raddr;
    logic                 w_we;
    shap_pkg::t_entry     w_wdata;
    shap_pkg::t_entry     w_rd;
    logic [EW-1:0]        w_rdata;
    logic                 w_div_start;
    logic [DVW-1:0]       w_div_dividend;
    logic [DSW-1:0]       w_div_divisor;
    logic                 w_div_done;
    logic [DVW-1:0]       w_div_quot;

    assign w_full = r_count == CW'(DEPTH);
    assign w_take = (r_state == ST_IDLE) && i_task_valid && !r_ovalid;
    assign o_task_ready = w_take;

    // slot of the entry age places back from the newest
    assign w_hit = XW'(i_task.age) < XW'(r_count);
    always_comb begin
        w_back = XW'(r_wp) - XW'(1) - XW'(i_task.age);
        if (w_back[XW-1]) begin
            w_back = w_back + XW'(DEPTH);
        end
        w_slot = w_back[PW-1:0];
    end

    assign w_raddr = (i_task.op == shap_pkg::OP_STORE) ? r_wp : w_slot;
    assign w_rd    = w_rdata;
    assign w_wdata = '{row: r_row, reading: r_task.sample};

    shap_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    shap_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    always_comb begin
        n_state        = r_state;
        n_wp           = r_wp;
        n_count        = r_count;
        n_sum          = r_sum;
        n_avg          = r_avg;
        n_row          = r_row;
        n_task         = r_task;
        n_ovalid       = r_ovalid & ~i_out_ready;
        n_out          = r_out;
        w_we           = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = '0;
        w_div_divisor  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_task = i_task;
                    unique case (i_task.op)
                        shap_pkg::OP_STORE: begin
                            n_state = ST_EVICT;
                        end
                        shap_pkg::OP_READ: begin
                            if (w_hit) begin
                                n_state = ST_READ;
                            end else begin
                                n_ovalid = 1'b1;
                                n_out    = '{plot_row: '0, entry_value: '0,
                                             window_average: r_avg,
                                             held_count: shap_pkg::COUNT_W'(r_count),
                                             empty_flag: 1'b1};
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                            n_out    = '{plot_row: '0, entry_value: '0,
                                         window_average: r_avg,
                                         held_count: shap_pkg::COUNT_W'(r_count),
                                         empty_flag: (r_count == '0)};
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_ovalid = 1'b1;
                n_out    = '{plot_row: w_rd.row, entry_value: w_rd.reading,
                             window_average: r_avg,
                             held_count: shap_pkg::COUNT_W'(r_count),
                             empty_flag: 1'b0};
                n_state  = ST_IDLE;
            end
            ST_EVICT: begin
                // oldest reading leaves the sum once the ring is full
                n_sum = r_sum - (w_full ? SUMW'(w_rd.reading) : '0) + SUMW'(r_task.sample);
                if (!w_full) begin
                    n_count = r_count + CW'(1);
                end
                unique case (r_task.cls)
                    shap_pkg::ROW_ZERO: begin
                        n_row   = '0;
                        n_state = ST_WR;
                    end
                    shap_pkg::ROW_MAX: begin
                        n_row   = r_task.pmax;
                        n_state = ST_WR;
                    end
                    default: begin
                        w_div_start    = 1'b1;
                        w_div_dividend = DVW'(r_task.num);
                        w_div_divisor  = DSW'(r_task.den);
                        n_state        = ST_ROW;
                    end
                endcase
            end
            ST_ROW: begin
                if (w_div_done) begin
                    n_row   = w_div_quot[shap_pkg::ROW_W-1:0];
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                w_we           = 1'b1;
                n_wp           = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
                w_div_start    = 1'b1;
                w_div_dividend = DVW'(r_sum);
                w_div_divisor  = DSW'(r_count);
                n_state        = ST_AVG;
            end
            ST_AVG: begin
                if (w_div_done) begin
                    n_avg    = w_div_quot[shap_pkg::SAMPLE_W-1:0];
                    n_ovalid = 1'b1;
                    n_out    = '{plot_row: r_row, entry_value: r_task.sample,
                                 window_average: w_div_quot[shap_pkg::SAMPLE_W-1:0],
                                 held_count: shap_pkg::COUNT_W'(r_count),
                                 empty_flag: 1'b0};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wp     <= '0;
            r_count  <= '0;
            r_sum    <= '0;
            r_avg    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_avg    <= n_avg;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_task <= n_task;
        r_out  <= n_out;
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_data   = r_out;
    assign o_stat.empty = r_count == '0;
    assign o_stat.full  = w_full;

endmodule

`default_nettype wire

### rtl/sample_history_average_plot_top.sv
// sample_history_average_plot_top: sample ring with window average and plot rows
// depends on shap_pkg, shap_front and shap_back
//
//  port group  dir  handshake                   payload
//  cfg         in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//  in          in   i_in_valid / o_in_ready     i_in_data (shap_pkg::t_in)
//  out         out  o_out_valid / i_out_ready   o_out_data (shap_pkg::t_out)
//
// a report or a missed read passes the task queue and the result register; a read hit also ST_READ
// a store passes ST_EVICT, ST_ROW, ST_WR and ST_AVG, and skips ST_ROW when the
// reading lies outside the range: the shared divider (DVW = 24 at DEPTH 144) yields one quotient bit per cycle
// a two entry task queue takes items while the back end works or the result waits
// synchronous active low reset clears pointers, count, sum and average; no clearing pass
`default_nettype none

module sample_history_average_plot_top #(
    parameter int DEPTH = shap_pkg::DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [shap_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [shap_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire shap_pkg::t_in                    i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output shap_pkg::t_out                        o_out_data
);

    logic                w_task_valid;
    logic                w_task_ready;
    shap_pkg::t_task     w_task;
    shap_pkg::t_bk_stat  w_stat;

    shap_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_task_valid (w_task_valid),
        .i_task_ready (w_task_ready),
        .o_task       (w_task)
    );

    shap_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (w_task_valid),
        .o_task_ready (w_task_ready),
        .i_task       (w_task),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data),
        .o_stat       (w_stat)
    );

    // an empty window reports nothing but zeros and the empty flag
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && w_stat.empty |-> o_out_data.empty_flag &&
        o_out_data.window_average == '0 && o_out_data.entry_value == '0)
        else $error("result from empty window carries data");

    // once full, the ring stays full until reset
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_stat.full) |-> w_stat.full)
        else $error("ring lost its full state");

    // a result without the empty flag needs held readings
    a_hit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.empty_flag |-> !w_stat.empty)
        else $error("non-empty result while nothing held");

endmodule

`default_nettype wire
